FILE: rtl/wsa_pkg.sv
// ----------------------------------------------------------------------------
// wsa_pkg
// shared types and constants of the 3x3 window sum / argmax block
// ----------------------------------------------------------------------------
package wsa_pkg;

	localparam int MAX_DIM     = 32;
	localparam int CELL_BITS   = 16;
	localparam int IDX_BITS    = $clog2(MAX_DIM);
	localparam int DIM_BITS    = 6;
	localparam int ADDR_BITS   = 2 * IDX_BITS;
	localparam int SUM_BITS    = 20;
	localparam int ACC_BITS    = CELL_BITS + 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS = 1'b1;

	typedef struct packed {
		logic [CELL_BITS-1:0] value;
		logic [IDX_BITS-1:0]  row;
		logic [IDX_BITS-1:0]  col;
		logic                 last;
	} cell_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		logic [SUM_BITS-1:0] sum;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN,
		BK_DONE
	} back_state_t;

endpackage

FILE: rtl/wsa_front.sv
// ----------------------------------------------------------------------------
// wsa_front
// accepts cells, tracks their grid position and marks the last cell of a grid
// ----------------------------------------------------------------------------
module wsa_front import wsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                restart,
	input  logic [DIM_BITS-1:0] grid_rows,
	input  logic [DIM_BITS-1:0] grid_cols,
	input  logic                q_full,
	output logic                q_push,
	output cell_item_t          q_item
);

	logic [IDX_BITS-1:0] row_q;
	logic [IDX_BITS-1:0] col_q;
	logic                row_end;
	logic                col_end;

	assign full    = q_full;
	assign q_push  = push && !q_full;
	assign col_end = ({1'b0, col_q} == grid_cols - DIM_BITS'(1));
	assign row_end = ({1'b0, row_q} == grid_rows - DIM_BITS'(1));

	always_comb begin
		q_item.row  = row_q;
		q_item.col  = col_q;
		q_item.last = row_end && col_end;
		q_item.value = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (q_push) begin
			if (col_end) begin
				col_q <= '0;
				// wrap to the top once the grid is complete
				row_q <= row_end ? '0 : row_q + IDX_BITS'(1);
			end else begin
				col_q <= col_q + IDX_BITS'(1);
			end
		end
	end

endmodule

FILE: rtl/wsa_queue.sv
// ----------------------------------------------------------------------------
// wsa_queue
// short item queue between the front and the back
// ----------------------------------------------------------------------------
module wsa_queue import wsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cell_item_t push_item,
	output logic       full,
	input  logic       pop,
	output cell_item_t pop_item,
	output logic       empty
);

	cell_item_t           entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/wsa_back.sv
// ----------------------------------------------------------------------------
// wsa_back
// stores cells in the grid memory and scans all clipped 3x3 windows
// ----------------------------------------------------------------------------
module wsa_back import wsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [DIM_BITS-1:0] grid_rows,
	input  logic [DIM_BITS-1:0] grid_cols,
	input  logic                q_empty,
	input  cell_item_t          q_item,
	output logic                q_pop,
	input  logic                out_free,
	output logic                res_valid,
	output result_t             res
);

	function automatic logic [IDX_BITS-1:0] win_lo(input logic [IDX_BITS-1:0] x);
		win_lo = (x == '0) ? '0 : x - IDX_BITS'(1);
	endfunction

	function automatic logic [IDX_BITS-1:0] win_hi(input logic [IDX_BITS-1:0] x,
		input logic [DIM_BITS-1:0] n);
		logic [DIM_BITS-1:0] nxt;
		logic [DIM_BITS-1:0] top;
		nxt = {1'b0, x} + DIM_BITS'(1);
		top = n - DIM_BITS'(1);
		win_hi = (nxt < n) ? nxt[IDX_BITS-1:0] : top[IDX_BITS-1:0];
	endfunction

	logic [CELL_BITS-1:0] mem [MAX_DIM*MAX_DIM];

	back_state_t state_q, state_d;

	logic [IDX_BITS-1:0] ci_q, cj_q, wi_q, wj_q;
	logic [IDX_BITS-1:0] ci_d, cj_d, wi_d, wj_d;
	logic [IDX_BITS-1:0] r0, r1, c0, c1;
	logic                win_last, last_center, row_wrap;

	logic                 mem_we;
	logic                 rd_en;
	logic [ADDR_BITS-1:0] mem_addr;

	logic [CELL_BITS-1:0] rd_data_s1;
	logic                 rd_valid_s1;
	logic                 first_s1;
	logic                 last_s1;
	logic [IDX_BITS-1:0]  ci_s1, cj_s1;

	logic [ACC_BITS-1:0] acc_q;
	logic [ACC_BITS-1:0] acc_sum;
	logic [SUM_BITS-1:0] win_sum;
	logic [SUM_BITS-1:0] best_q;
	logic [IDX_BITS-1:0] brow_q, bcol_q;
	logic                first_win_s1;

	assign r0 = win_lo(ci_q);
	assign r1 = win_hi(ci_q, grid_rows);
	assign c0 = win_lo(cj_q);
	assign c1 = win_hi(cj_q, grid_cols);
	assign win_last    = (wi_q == r1) && (wj_q == c1);
	assign row_wrap    = ({1'b0, cj_q} == grid_cols - DIM_BITS'(1));
	assign last_center = row_wrap && ({1'b0, ci_q} == grid_rows - DIM_BITS'(1));

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		mem_addr = {q_item.row, q_item.col};
		ci_d     = ci_q;
		cj_d     = cj_q;
		wi_d     = wi_q;
		wj_d     = wj_q;
		res_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop  = 1'b1;
					mem_we = 1'b1;
					if (q_item.last) begin
						state_d = BK_SCAN;
						ci_d = '0;
						cj_d = '0;
						wi_d = '0;
						wj_d = '0;
					end
				end
			end
			BK_SCAN: begin
				rd_en    = 1'b1;
				mem_addr = {wi_q, wj_q};
				if (win_last) begin
					if (last_center) begin
						state_d = BK_DRAIN;
					end else begin
						if (row_wrap) begin
							cj_d = '0;
							ci_d = ci_q + IDX_BITS'(1);
						end else begin
							cj_d = cj_q + IDX_BITS'(1);
						end
						wi_d = win_lo(ci_d);
						wj_d = win_lo(cj_d);
					end
				end else if (wj_q == c1) begin
					wj_d = c0;
					wi_d = wi_q + IDX_BITS'(1);
				end else begin
					wj_d = wj_q + IDX_BITS'(1);
				end
			end
			BK_DRAIN: begin
				state_d = BK_DONE;
			end
			BK_DONE: begin
				res_valid = 1'b1;
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ci_q    <= '0;
			cj_q    <= '0;
			wi_q    <= '0;
			wj_q    <= '0;
		end else begin
			state_q <= state_d;
			ci_q    <= ci_d;
			cj_q    <= cj_d;
			wi_q    <= wi_d;
			wj_q    <= wj_d;
		end
	end

	// grid memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= q_item.value;
		end
		rd_data_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (wi_q == r0) && (wj_q == c0);
		last_s1  <= win_last;
		ci_s1    <= ci_q;
		cj_s1    <= cj_q;
	end

	// accumulate one read per cycle, compare at the end of each window
	assign acc_sum      = (first_s1 ? '0 : acc_q) + ACC_BITS'(rd_data_s1);
	assign win_sum      = (acc_sum > ACC_BITS'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_BITS-1:0];
	assign first_win_s1 = (ci_s1 == '0) && (cj_s1 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			best_q <= '0;
			brow_q <= '0;
			bcol_q <= '0;
		end else if (rd_valid_s1) begin
			acc_q <= acc_sum;
			if (last_s1 && (first_win_s1 || win_sum > best_q)) begin
				best_q <= win_sum;
				brow_q <= ci_s1;
				bcol_q <= cj_s1;
			end
		end
	end

	always_comb begin
		res.row = brow_q;
		res.col = bcol_q;
		res.sum = best_q;
	end

endmodule

FILE: rtl/window_sum_argmax_3x3.sv
// ----------------------------------------------------------------------------
// window_sum_argmax_3x3
// 3x3 box-filter sum over a loaded grid with argmax of the window sums
// ----------------------------------------------------------------------------
// usage:
//   configuration: write grid_rows (index 0) and grid_cols (index 1) on the
//   cfg channel while the block is idle; 0 reads as 1, above 32 reads as 32.
//   any write restarts loading of the grid. cfg_ready is always high.
//   input: one cell_value item per push, row-major order; full stalls the
//   sender. a four-entry queue feeds grid memory, one a cycle while back idles.
//   result: after the last cell of a grid the back scans every clipped 3x3
//   window with one memory read a cycle (up to nine reads a window), then
//   shows best_row, best_col, best_sum while empty is low until popped.
//   scan time grows with the sum of window sizes, since the single memory
//   read port gives one read at a time. loading runs at one cell a cycle
//   while the back is idle.
//   while the result waits unpopped the front still takes cells into the
//   queue; the back holds the next grid until the result slot frees.
//   reset clears the queue, load position and result slot; config returns
//   to 1x1. grid memory contents are not cleared.
// ----------------------------------------------------------------------------
module window_sum_argmax_3x3 import wsa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// cell input
	input  logic                    push,
	output logic                    full,
	input  logic [CELL_BITS-1:0]    cell_value,
	// result output
	output logic                    empty,
	input  logic                    pop,
	output logic [IDX_BITS-1:0]     best_row,
	output logic [IDX_BITS-1:0]     best_col,
	output logic [SUM_BITS-1:0]     best_sum,
	// configuration
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]     cfg_data
);

	logic [DIM_BITS-1:0] grid_rows_q;
	logic [DIM_BITS-1:0] grid_cols_q;
	logic [DIM_BITS-1:0] cfg_dim;
	logic                cfg_wr;

	cell_item_t front_item;
	cell_item_t q_in_item;
	cell_item_t q_out_item;
	logic       q_push, q_full, q_pop, q_empty;

	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;
	logic    out_free;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// clamp size into 1..MAX_DIM
	always_comb begin
		if (cfg_data == '0) begin
			cfg_dim = DIM_BITS'(1);
		end else if (cfg_data > DIM_BITS'(MAX_DIM)) begin
			cfg_dim = DIM_BITS'(MAX_DIM);
		end else begin
			cfg_dim = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= DIM_BITS'(1);
			grid_cols_q <= DIM_BITS'(1);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_dim;
				REG_GRID_COLS: grid_cols_q <= cfg_dim;
				default: ;
			endcase
		end
	end

	wsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.restart   (cfg_wr),
		.grid_rows (grid_rows_q),
		.grid_cols (grid_cols_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (front_item)
	);

	// cell payload joins the position tag from the front
	always_comb begin
		q_in_item       = front_item;
		q_in_item.value = cell_value;
	end

	wsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out_item),
		.empty     (q_empty)
	);

	wsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_rows (grid_rows_q),
		.grid_cols (grid_cols_q),
		.q_empty   (q_empty),
		.q_item    (q_out_item),
		.q_pop     (q_pop),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// one-entry result slot; refills in the cycle it is popped
	assign out_free = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign empty    = !out_valid_q;
	assign best_row = out_q.row;
	assign best_col = out_q.col;
	assign best_sum = out_q.sum;

endmodule

FILE: rtl/wsa_chk.sv
// ----------------------------------------------------------------------------
// wsa_chk
// port-level checks of the window sum / argmax block
// ----------------------------------------------------------------------------
module wsa_chk import wsa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input logic [IDX_BITS-1:0] best_row,
	input logic [IDX_BITS-1:0] best_col,
	input logic [SUM_BITS-1:0] best_sum
);

	localparam logic [SUM_BITS-1:0] SUM_BOUND = SUM_BITS'(9 * ((1 << CELL_BITS) - 1));

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(best_sum) && $stable(best_row)
			&& $stable(best_col)))
		else $error("result changed while waiting");

	// nine cells bound any window sum
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (best_sum <= SUM_BOUND))
		else $error("window sum out of range");

	// no result can follow reset directly
	a_reset: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result present after reset");

endmodule

bind window_sum_argmax_3x3 wsa_chk u_wsa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.best_row (best_row),
	.best_col (best_col),
	.best_sum (best_sum)
);
